// ----- rtl/core/qsu_pkg.sv -----
// qsu_pkg: item types, character codes and the hex digit helper
// shared by the quoted string unescaper interfaces and modules; no dependencies
package qsu_pkg;

	localparam int LEN_W = 16;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic             byte_valid;
		logic [7:0]       decoded_byte;
		logic             done_res;
		logic             status;
		logic [LEN_W-1:0] decoded_length;
	} out_item_t;

	// status codes carried with done
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// raw characters
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_BACKTICK  = 8'h60;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_U         = 8'h75;

	// decoded control characters
	localparam logic [7:0] CODE_NUL = 8'h00;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_MAX = 8'hFF;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// {ok, value}: ok low when the byte is not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c inside {[8'h30:8'h39]}) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (c inside {[8'h61:8'h66]}) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		if (c inside {[8'h41:8'h46]}) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		return 5'b0_0000;
	endfunction

endpackage

// ----- rtl/core/qsu_if.sv -----
// qsu_if: valid/ready channel interfaces for raw bytes and decoded results
// depends on qsu_pkg for the payload types
interface qsu_in_if;
	logic               valid;
	logic               ready;
	qsu_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qsu_out_if;
	logic               valid;
	logic               ready;
	qsu_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/qsu_in_stage.sv -----
// qsu_in_stage: input register for raw bytes
// depends on qsu_pkg and qsu_in_if
module qsu_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	qsu_in_if.sink            raw,
	input  logic              pop,
	output logic              valid,
	output qsu_pkg::in_item_t item
);
	import qsu_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign raw.ready = !valid_s1 || pop;
	assign valid     = valid_s1;
	assign item      = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.valid && raw.ready) begin
			valid_s1 <= 1'b1;
		end else if (pop) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			item_s1 <= raw.data;
		end
	end

endmodule

// ----- rtl/core/qsu_decoder.sv -----
// qsu_decoder: phase machine and escape decode for one byte per step
// depends on qsu_pkg
module qsu_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  qsu_pkg::in_item_t  item,
	output qsu_pkg::out_item_t res,
	output logic               has_res
);
	import qsu_pkg::*;

	localparam logic [2:0] PH_OPEN = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_ESC  = 3'd2;
	localparam logic [2:0] PH_HEX  = 3'd3;
	localparam logic [2:0] PH_ERR  = 3'd4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [2:0]            phase_q,  phase_d;
	logic [7:0]            delim_q,  delim_d;
	logic                  wide_q,   wide_d;
	logic [2:0]            digits_q, digits_d;
	logic [15:0]           acc_q,    acc_d;
	logic [COUNT_BITS-1:0] count_q,  count_d;

	logic [7:0]  c;
	logic [4:0]  hex_d;
	logic [15:0] acc_shift;
	logic [2:0]  digits_dec;
	logic [31:0] count_ext;
	logic [LEN_W-1:0] len_sat;
	logic        emit;
	logic [7:0]  emit_val;

	assign c          = item.char_in;
	assign hex_d      = hex_digit(c);
	assign acc_shift  = {acc_q[11:0], hex_d[3:0]};
	assign digits_dec = (digits_q != 3'd0) ? digits_q - 3'd1 : 3'd0;
	assign count_ext  = 32'(count_q);
	assign len_sat    = (count_ext > 32'(LEN_MAX)) ? LEN_MAX : count_ext[LEN_W-1:0];

	always_comb begin
		phase_d  = phase_q;
		delim_d  = delim_q;
		wide_d   = wide_q;
		digits_d = digits_q;
		acc_d    = acc_q;
		count_d  = count_q;
		res      = '0;
		has_res  = 1'b0;
		emit     = 1'b0;
		emit_val = 8'h00;
		if (item.last_in) begin
			has_res            = 1'b1;
			res.done_res       = 1'b1;
			res.status         = (phase_q == PH_BODY && c == delim_q) ? STATUS_OK : STATUS_BAD;
			res.decoded_length = len_sat;
			phase_d  = PH_OPEN;
			delim_d  = 8'h00;
			wide_d   = 1'b0;
			digits_d = 3'd0;
			acc_d    = 16'h0000;
			count_d  = '0;
		end else begin
			case (phase_q)
				PH_OPEN: begin
					if (c inside {CH_DQUOTE, CH_SQUOTE, CH_BACKTICK}) begin
						delim_d = c;
						phase_d = PH_BODY;
					end else begin
						phase_d = PH_ERR;
					end
				end
				PH_BODY: begin
					if (c == CH_BACKSLASH) begin
						phase_d = PH_ESC;
					end else begin
						emit     = 1'b1;
						emit_val = c;
					end
				end
				PH_ESC: begin
					phase_d = PH_BODY;
					case (c)
						CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE, CH_BACKTICK, CH_SLASH: begin
							emit     = 1'b1;
							emit_val = c;
						end
						CH_ZERO: begin
							emit     = 1'b1;
							emit_val = CODE_NUL;
						end
						CH_B: begin
							emit     = 1'b1;
							emit_val = CODE_BS;
						end
						CH_T: begin
							emit     = 1'b1;
							emit_val = CODE_TAB;
						end
						CH_N: begin
							emit     = 1'b1;
							emit_val = CODE_LF;
						end
						CH_R: begin
							emit     = 1'b1;
							emit_val = CODE_CR;
						end
						CH_X: begin
							phase_d  = PH_HEX;
							wide_d   = 1'b0;
							digits_d = 3'd2;
							acc_d    = 16'h0000;
						end
						CH_U: begin
							phase_d  = PH_HEX;
							wide_d   = 1'b1;
							digits_d = 3'd4;
							acc_d    = 16'h0000;
						end
						default: begin
							phase_d = PH_ERR;
						end
					endcase
				end
				PH_HEX: begin
					if (!hex_d[4]) begin
						phase_d  = PH_ERR;
						digits_d = 3'd0;
					end else if (digits_dec != 3'd0) begin
						acc_d    = acc_shift;
						digits_d = digits_dec;
					end else begin
						// last digit: clamp wide values to one byte
						phase_d  = PH_BODY;
						emit     = 1'b1;
						emit_val = (wide_q && acc_shift[15:8] != 8'h00) ? BYTE_MAX
							: acc_shift[7:0];
						wide_d   = 1'b0;
						digits_d = 3'd0;
						acc_d    = 16'h0000;
					end
				end
				PH_ERR: begin
					phase_d = PH_ERR;
				end
				default: begin
					phase_d = PH_ERR;
				end
			endcase
			if (emit) begin
				has_res          = 1'b1;
				res.byte_valid   = 1'b1;
				res.decoded_byte = emit_val;
				if (count_q != COUNT_MAX) begin
					count_d = count_q + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPEN;
			delim_q  <= 8'h00;
			wide_q   <= 1'b0;
			digits_q <= 3'd0;
			acc_q    <= 16'h0000;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			delim_q  <= delim_d;
			wide_q   <= wide_d;
			digits_q <= digits_d;
			acc_q    <= acc_d;
			count_q  <= count_d;
		end
	end

`ifndef SYNTH
	a_done_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_in |=> phase_q == PH_OPEN && count_q == '0)
		else $error("phase machine not back at opening quote after done");
	a_digits_only_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEX |-> digits_q == 3'd0)
		else $error("hex digit count pending outside hex phase");
	a_open_has_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OPEN |-> count_q == '0)
		else $error("decoded count nonzero before opening quote");
	a_one_kind_of_result: assert property (@(posedge clk) disable iff (!arst_n)
		has_res |-> res.byte_valid != res.done_res)
		else $error("result is both or neither a byte and a done");
`endif

endmodule

// ----- rtl/core/qsu_out_stage.sv -----
// qsu_out_stage: result register toward the consumer
// depends on qsu_pkg and qsu_out_if
module qsu_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  qsu_pkg::out_item_t res,
	output logic               free,
	qsu_out_if.source          decoded
);
	import qsu_pkg::*;

	logic      out_v_q;
	out_item_t out_q;

	assign free          = !out_v_q || decoded.ready;
	assign decoded.valid = out_v_q;
	assign decoded.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (decoded.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/core/quoted_string_unescaper.sv -----
// flow: an accepted byte is held in the input register and decoded from there
//   combinationally; its result is loaded into the result register and offered from it
// throughput: one byte per cycle while the result register has room for results
// reset: arst_n clears both valid flags and returns the phase machine to
//   waiting for an opening quote with a zero count
// quoted_string_unescaper: top level, input register, decoder, result register
// depends on qsu_pkg, qsu_if, qsu_in_stage, qsu_decoder, qsu_out_stage
module quoted_string_unescaper #(
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	qsu_in_if.sink    raw,
	qsu_out_if.source decoded
);
	import qsu_pkg::*;

	// held raw byte and its decode
	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t res;
	logic      has_res;

	// room in the result register for this cycle's transaction
	logic      free;

	// a held byte retires when it makes no result, or its result has room
	logic      pop;
	logic      load;

	assign pop  = valid_s1 && (!has_res || free);
	assign load = pop && has_res;

	// input register: takes a new byte whenever the held one retires
	qsu_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.pop    (pop),
		.valid  (valid_s1),
		.item   (item_s1)
	);

	// phase machine advances only on a retiring byte
	qsu_decoder #(
		.COUNT_BITS (COUNT_BITS)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (pop),
		.item    (item_s1),
		.res     (res),
		.has_res (has_res)
	);

	// result register: while a result waits untaken, a held byte with a result stalls
	qsu_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.res     (res),
		.free    (free),
		.decoded (decoded)
	);

endmodule
